FILE: src/btidx_pkg.sv
// Shared types and constants for the B-tree index node engine.
`default_nettype none

package btidx_pkg;

  localparam int KEY_W = 64;

  // Request operation codes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_ADD    = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_SPLIT  = 3'd4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_SPLIT = 3'd4
  } node_status_t;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_INIT0,
    CMD_INIT1,
    CMD_POS_ZERO,
    CMD_SCAN_START,
    CMD_SCAN,
    CMD_FETCH,
    CMD_UPD_WR,
    CMD_SHIFT_SETUP,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_ADD_WR,
    CMD_SPLIT_START,
    CMD_SPLIT_RD,
    CMD_EMIT_ZERO,
    CMD_EMIT_ENTRY,
    CMD_EMIT_REQ,
    CMD_EMIT_SPLIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t       op;
    node_status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       used_zero;
    logic       used_le1;
    logic       full;
    logic       split_bad;
    logic       split_none;
    logic       scan_stop;
    logic       shift_more;
    logic       key_match;
    logic       split_more;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/btidx_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module btidx_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/btidx_ctrl.sv
// Controller state machine sequencing node operations over the datapath.
`default_nettype none

module btidx_ctrl import btidx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INIT1,
    S_SCAN,
    S_FETCH,
    S_UPD_CHK,
    S_SHIFT_SETUP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REQ_EMIT,
    S_ENTRY_EMIT,
    S_ZERO_EMIT,
    S_SPLIT_RD,
    S_SPLIT_EMIT
  } state_t;

  state_t       state_r, state_nxt;
  node_status_t code_r, code_nxt;
  dp_op_t       op_cmd;
  state_t       after_scan;

  // After the position is known, add shifts while the others fetch the entry
  assign after_scan = (status.op == OP_ADD) ? S_SHIFT_SETUP : S_FETCH;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    op_cmd    = CMD_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_cmd    = CMD_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        code_nxt = ST_OK;
        unique case (status.op) inside
          OP_INIT: begin
            op_cmd    = CMD_INIT0;
            state_nxt = S_INIT1;
          end
          OP_LOOKUP, OP_ADD, OP_UPDATE: begin
            if (status.used_zero) begin
              code_nxt  = ST_EMPTY;
              state_nxt = S_ZERO_EMIT;
            end else if (status.op == OP_ADD && status.full) begin
              code_nxt  = ST_FULL;
              state_nxt = S_ZERO_EMIT;
            end else if (status.used_le1) begin
              op_cmd    = CMD_POS_ZERO;
              state_nxt = after_scan;
            end else begin
              op_cmd    = CMD_SCAN_START;
              state_nxt = S_SCAN;
            end
          end
          OP_SPLIT: begin
            if (status.split_bad) begin
              code_nxt  = ST_BAD_SPLIT;
              state_nxt = S_ZERO_EMIT;
            end else if (status.split_none) begin
              state_nxt = S_ZERO_EMIT;
            end else begin
              op_cmd    = CMD_SPLIT_START;
              state_nxt = S_SPLIT_RD;
            end
          end
          default: begin
            // drop unknown operations without a result
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_INIT1: begin
        op_cmd    = CMD_INIT1;
        state_nxt = S_ZERO_EMIT;
      end
      S_SCAN: begin
        op_cmd = CMD_SCAN;
        if (status.scan_stop) begin
          state_nxt = after_scan;
        end
      end
      S_FETCH: begin
        op_cmd    = CMD_FETCH;
        state_nxt = (status.op == OP_UPDATE) ? S_UPD_CHK : S_ENTRY_EMIT;
      end
      S_UPD_CHK: begin
        if (status.key_match) begin
          op_cmd    = CMD_UPD_WR;
          state_nxt = S_REQ_EMIT;
        end else begin
          code_nxt  = ST_NOT_FOUND;
          state_nxt = S_ENTRY_EMIT;
        end
      end
      S_SHIFT_SETUP: begin
        op_cmd    = CMD_SHIFT_SETUP;
        state_nxt = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (status.shift_more) begin
          op_cmd    = CMD_SHIFT_RD;
          state_nxt = S_SHIFT_WR;
        end else begin
          op_cmd    = CMD_ADD_WR;
          state_nxt = S_REQ_EMIT;
        end
      end
      S_SHIFT_WR: begin
        op_cmd    = CMD_SHIFT_WR;
        state_nxt = S_SHIFT_RD;
      end
      S_REQ_EMIT: begin
        if (status.out_free) begin
          op_cmd    = CMD_EMIT_REQ;
          state_nxt = S_IDLE;
        end
      end
      S_ENTRY_EMIT: begin
        if (status.out_free) begin
          op_cmd    = CMD_EMIT_ENTRY;
          state_nxt = S_IDLE;
        end
      end
      S_ZERO_EMIT: begin
        if (status.out_free) begin
          op_cmd    = CMD_EMIT_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_SPLIT_RD: begin
        op_cmd    = CMD_SPLIT_RD;
        state_nxt = S_SPLIT_EMIT;
      end
      S_SPLIT_EMIT: begin
        if (status.out_free) begin
          op_cmd    = CMD_EMIT_SPLIT;
          state_nxt = status.split_more ? S_SPLIT_RD : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign cmd.op   = op_cmd;
  assign cmd.code = code_r;
  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

FILE: src/btidx_dpath.sv
// Datapath: entry memory, request latch, counters and result register.
`default_nettype none

module btidx_dpath import btidx_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [2:0]       in_op,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [KEY_W-1:0] in_child,
  input  wire logic [KEY_W-1:0] in_second_child,
  input  wire logic [1:0]       in_root_count,
  input  wire logic [6:0]       in_split_pos,
  input  wire logic             cfg_we,
  input  wire logic [6:0]       cfg_wdata,
  input  wire dp_cmd_t          cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_status,
  output logic [5:0]            out_entry_index,
  output logic [KEY_W-1:0]      out_key,
  output logic [KEY_W-1:0]      out_child,
  output logic [6:0]            out_entry_total,
  output logic                  out_last
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int ENT_W  = 2 * KEY_W;

  // Request latch (payload)
  logic [2:0]       op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] child_r, child_nxt;
  logic [KEY_W-1:0] second_r, second_nxt;
  logic [1:0]       rc_r, rc_nxt;
  logic [6:0]       spos_r, spos_nxt;

  // Node state and walk counters
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [6:0]       cap_r, cap_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;

  // Result register
  logic             ovalid_r, ovalid_nxt;
  logic [2:0]       ostatus_r, ostatus_nxt;
  logic [5:0]       oindex_r, oindex_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;
  logic [KEY_W-1:0] ochild_r, ochild_nxt;
  logic [6:0]       ototal_r, ototal_nxt;
  logic             olast_r, olast_nxt;

  // Memory port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [KEY_W-1:0]  rd_child;

  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic [CMP_W-1:0]  used_ext;
  logic [CMP_W-1:0]  spos_ext;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  split_off;
  logic              scan_gt;
  logic              scan_end;

  btidx_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_key   = ram_rdata[ENT_W-1:KEY_W];
  assign rd_child = ram_rdata[KEY_W-1:0];

  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  assign used_ext = CMP_W'(used_r);
  assign spos_ext = CMP_W'(spos_r);
  assign cap_ext  = CMP_W'(cap_r);
  assign split_off = CMP_W'(idx_r) - spos_ext;

  // Clamp the capacity to one up to the memory depth
  always_comb begin
    if (cap_r == 7'd0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign scan_gt  = (rd_key > key_r);
  assign scan_end = (idx_inc >= used_r);

  // Status towards the controller
  assign status.op         = op_r;
  assign status.used_zero  = (used_r == '0);
  assign status.used_le1   = (used_r <= CNT_W'(1));
  assign status.full       = (used_ext >= cap_eff);
  assign status.split_bad  = (spos_ext > used_ext);
  assign status.split_none = (spos_ext == used_ext);
  assign status.scan_stop  = scan_gt || scan_end;
  assign status.shift_more = (idx_r > pos_r);
  assign status.key_match  = (rd_key == key_r);
  assign status.split_more = (idx_inc < end_r);
  assign status.out_free   = !ovalid_r || !out_stall;

  // Command decode
  always_comb begin
    op_nxt      = op_r;
    key_nxt     = key_r;
    child_nxt   = child_r;
    second_nxt  = second_r;
    rc_nxt      = rc_r;
    spos_nxt    = spos_r;
    used_nxt    = used_r;
    cap_nxt     = cfg_we ? cfg_wdata : cap_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    end_nxt     = end_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[ADDR_W-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_r[ADDR_W-1:0];
    // drop the result once taken
    ovalid_nxt  = ovalid_r && out_stall;
    ostatus_nxt = ostatus_r;
    oindex_nxt  = oindex_r;
    okey_nxt    = okey_r;
    ochild_nxt  = ochild_r;
    ototal_nxt  = ototal_r;
    olast_nxt   = olast_r;
    unique case (cmd.op)
      CMD_LOAD: begin
        op_nxt     = in_op;
        key_nxt    = in_key;
        child_nxt  = in_child;
        second_nxt = in_second_child;
        rc_nxt     = in_root_count;
        spos_nxt   = in_split_pos;
        idx_nxt    = CNT_W'(1);
      end
      CMD_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {{KEY_W{1'b0}}, child_r};
      end
      CMD_INIT1: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(1);
        ram_wdata = {key_r, second_r};
        // root counts of zero and three fold to one and two
        used_nxt  = rc_r[1] ? CNT_W'(2) : CNT_W'(1);
      end
      CMD_POS_ZERO: begin
        pos_nxt = '0;
      end
      CMD_SCAN_START: begin
        ram_re = 1'b1;
      end
      CMD_SCAN: begin
        if (scan_gt) begin
          pos_nxt = idx_dec;
        end else if (scan_end) begin
          pos_nxt = idx_r;
        end else begin
          // advance and read the next entry
          idx_nxt   = idx_inc;
          ram_re    = 1'b1;
          ram_raddr = idx_inc[ADDR_W-1:0];
        end
      end
      CMD_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = pos_r[ADDR_W-1:0];
      end
      CMD_UPD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[ADDR_W-1:0];
        ram_wdata = {rd_key, child_r};
      end
      CMD_SHIFT_SETUP: begin
        pos_nxt = pos_r + CNT_W'(1);
        idx_nxt = used_r;
      end
      CMD_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_dec[ADDR_W-1:0];
      end
      CMD_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
      end
      CMD_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[ADDR_W-1:0];
        ram_wdata = {key_r, child_r};
        used_nxt  = used_r + CNT_W'(1);
      end
      CMD_SPLIT_START: begin
        idx_nxt  = CNT_W'(spos_r);
        end_nxt  = used_r;
        used_nxt = CNT_W'(spos_r);
      end
      CMD_SPLIT_RD: begin
        ram_re = 1'b1;
      end
      CMD_EMIT_ZERO: begin
        ovalid_nxt  = 1'b1;
        ostatus_nxt = cmd.code;
        oindex_nxt  = '0;
        okey_nxt    = '0;
        ochild_nxt  = '0;
        ototal_nxt  = 7'(used_r);
        olast_nxt   = 1'b1;
      end
      CMD_EMIT_ENTRY: begin
        ovalid_nxt  = 1'b1;
        ostatus_nxt = cmd.code;
        oindex_nxt  = 6'(pos_r);
        okey_nxt    = rd_key;
        ochild_nxt  = rd_child;
        ototal_nxt  = 7'(used_r);
        olast_nxt   = 1'b1;
      end
      CMD_EMIT_REQ: begin
        ovalid_nxt  = 1'b1;
        ostatus_nxt = cmd.code;
        oindex_nxt  = 6'(pos_r);
        okey_nxt    = key_r;
        ochild_nxt  = child_r;
        ototal_nxt  = 7'(used_r);
        olast_nxt   = 1'b1;
      end
      CMD_EMIT_SPLIT: begin
        ovalid_nxt  = 1'b1;
        ostatus_nxt = cmd.code;
        oindex_nxt  = 6'(split_off);
        okey_nxt    = rd_key;
        ochild_nxt  = rd_child;
        ototal_nxt  = 7'(used_r);
        olast_nxt   = !status.split_more;
        idx_nxt     = idx_inc;
      end
      default: begin
      end
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    child_r   <= child_nxt;
    second_r  <= second_nxt;
    rc_r      <= rc_nxt;
    spos_r    <= spos_nxt;
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    end_r     <= end_nxt;
    ostatus_r <= ostatus_nxt;
    oindex_r  <= oindex_nxt;
    okey_r    <= okey_nxt;
    ochild_r  <= ochild_nxt;
    ototal_r  <= ototal_nxt;
    olast_r   <= olast_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      cap_r    <= 7'd64;
      ovalid_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      cap_r    <= cap_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_status      = ostatus_r;
  assign out_entry_index = oindex_r;
  assign out_key         = okey_r;
  assign out_child       = ochild_r;
  assign out_entry_total = ototal_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

FILE: src/btree_index_node_engine_core.sv
// Init writes the two root entries; lookup, update and add first scan for the position (none on a
// one-entry node) until a larger key stops the scan or it reaches the last entry; update then
// checks the key, add moves the later entries up one place. Split emits the tail one entry at a
// time; an empty node, full node, bad split or nothing to emit gives a single result with no entry.
// One request in work at a time, one entry read per cycle while scanning; a stalled result holds the engine.
// Synchronous active-low reset empties the node, sets the capacity to 64, keeps the memory.
`default_nettype none

module btree_index_node_engine_core import btidx_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       in_op,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [KEY_W-1:0] in_child,
  input  wire logic [KEY_W-1:0] in_second_child,
  input  wire logic [1:0]       in_root_count,
  input  wire logic [6:0]       in_split_pos,
  input  wire logic             cfg_we,
  input  wire logic [6:0]       cfg_wdata,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_status,
  output logic [5:0]            out_entry_index,
  output logic [KEY_W-1:0]      out_key,
  output logic [KEY_W-1:0]      out_child,
  output logic [6:0]            out_entry_total,
  output logic                  out_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the request
  btidx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the node and drive the result
  btidx_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_child        (in_child),
    .in_second_child (in_second_child),
    .in_root_count   (in_root_count),
    .in_split_pos    (in_split_pos),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_key         (out_key),
    .out_child       (out_child),
    .out_entry_total (out_entry_total),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

FILE: sim/tb_btree_index_node_engine_core.sv
// Self-checking testbench for the B-tree index node engine: directed table, then random requests.
module tb_btree_index_node_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import btidx_pkg::*;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // Reserved operation codes: the block drops them without a result
  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key;
    logic [63:0] child;
    logic [63:0] second_child;
    logic [1:0]  root_count;
    logic [6:0]  split_pos;
  } node_req_t;

  typedef struct packed {
    node_status_t status;
    logic [5:0]   entry_index;
    logic [63:0]  key;
    logic [63:0]  child;
    logic [6:0]   entry_total;
    logic         last;
  } node_result_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [6:0]   cfg_value;
    node_req_t    req;
    logic         typed;
    node_result_t want;
  } directed_row_t;

  // Results that follow directly from the request
  localparam node_result_t NO_RES       = '0;
  localparam node_result_t RES_EMPTY    = '{ST_EMPTY, 6'd0, 64'd0, 64'd0, 7'd0, 1'b1};
  localparam node_result_t RES_BAD_ZERO = '{ST_BAD_SPLIT, 6'd0, 64'd0, 64'd0, 7'd0, 1'b1};
  localparam node_result_t RES_OK_ZERO  = '{ST_OK, 6'd0, 64'd0, 64'd0, 7'd0, 1'b1};
  localparam node_result_t RES_INIT_ONE = '{ST_OK, 6'd0, 64'd0, 64'd0, 7'd1, 1'b1};
  localparam node_result_t RES_INIT_TWO = '{ST_OK, 6'd0, 64'd0, 64'd0, 7'd2, 1'b1};
  localparam node_result_t RES_FULL_ONE = '{ST_FULL, 6'd0, 64'd0, 64'd0, 7'd1, 1'b1};
  localparam node_result_t RES_FULL_TWO = '{ST_FULL, 6'd0, 64'd0, 64'd0, 7'd2, 1'b1};
  localparam node_req_t    NO_REQ       = '0;

  localparam int N_DIRECTED = 29;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_REQ, 7'd0, '{OP_LOOKUP, 64'd5, 64'd0, 64'd0, 2'd1, 7'd0}, 1'b1, RES_EMPTY},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd7, 64'd9, 64'd0, 2'd1, 7'd0}, 1'b1, RES_EMPTY},
    '{ROW_REQ, 7'd0, '{OP_UPDATE, 64'd0, 64'd1, 64'd0, 2'd1, 7'd0}, 1'b1, RES_EMPTY},
    '{ROW_REQ, 7'd0, '{OP_SPLIT, 64'd0, 64'd0, 64'd0, 2'd1, 7'd1}, 1'b1, RES_BAD_ZERO},
    '{ROW_REQ, 7'd0, '{OP_SPLIT, 64'd0, 64'd0, 64'd0, 2'd1, 7'd0}, 1'b1, RES_OK_ZERO},
    '{ROW_REQ, 7'd0, '{OP_UNUSED_5, 64'd3, 64'd3, 64'd3, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_INIT, ONES64, ONES64, 64'd0, 2'd0, 7'd0}, 1'b1, RES_INIT_ONE},
    '{ROW_REQ, 7'd0, '{OP_LOOKUP, 64'd0, 64'd0, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_INIT, 64'd100, 64'd11, 64'd22, 2'd3, 7'd0}, 1'b1, RES_INIT_TWO},
    '{ROW_REQ, 7'd0, '{OP_LOOKUP, 64'd99, 64'd0, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_LOOKUP, ONES64, 64'd0, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd50, 64'd33, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_ADD, ONES64, ONES64, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd0, 64'd44, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd100, 64'd55, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_UPDATE, 64'd100, 64'd66, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_UPDATE, 64'd101, 64'd77, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_SPLIT, 64'd0, 64'd0, 64'd0, 2'd3, 7'd127}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_SPLIT, 64'd0, 64'd0, 64'd0, 2'd1, 7'd2}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_UNUSED_6, ONES64, ONES64, ONES64, 2'd3, 7'd127}, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_UNUSED_7, 64'd0, 64'd0, 64'd0, 2'd0, 7'd0}, 1'b0, NO_RES},
    '{ROW_CFG, 7'd0, NO_REQ, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_INIT, 64'd5, 64'd1, 64'd2, 2'd1, 7'd0}, 1'b1, RES_INIT_ONE},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd9, 64'd9, 64'd0, 2'd1, 7'd0}, 1'b1, RES_FULL_ONE},
    '{ROW_REQ, 7'd0, '{OP_INIT, 64'd5, 64'd1, 64'd2, 2'd2, 7'd0}, 1'b1, RES_INIT_TWO},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd9, 64'd9, 64'd0, 2'd1, 7'd0}, 1'b1, RES_FULL_TWO},
    '{ROW_CFG, 7'd127, NO_REQ, 1'b0, NO_RES},
    '{ROW_REQ, 7'd0, '{OP_ADD, 64'd3, 64'd88, 64'd0, 2'd1, 7'd0}, 1'b0, NO_RES},
    '{ROW_CFG, 7'd64, NO_REQ, 1'b0, NO_RES}
  };

  // Random phases: capacity written first, request count, share of adds in percent
  localparam int PHASES = 5;
  localparam logic [6:0] PHASE_CAP [PHASES] = '{7'd127, 7'd3, 7'd64, 7'd0, 7'd64};
  localparam int PHASE_ITEMS [PHASES] = '{75, 30, 30, 35, 35};
  localparam int PHASE_ADD_PCT [PHASES] = '{90, 40, 45, 45, 50};

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_op;
  logic [KEY_W-1:0] in_key;
  logic [KEY_W-1:0] in_child;
  logic [KEY_W-1:0] in_second_child;
  logic [1:0]       in_root_count;
  logic [6:0]       in_split_pos;
  logic             cfg_we;
  logic [6:0]       cfg_wdata;
  logic             out_valid;
  logic             out_stall;
  logic [2:0]       out_status;
  logic [5:0]       out_entry_index;
  logic [KEY_W-1:0] out_key;
  logic [KEY_W-1:0] out_child;
  logic [6:0]       out_entry_total;
  logic             out_last;

  // Shadow copy of the node
  logic [63:0] shadow_keys [MAX_ENTRIES];
  logic [63:0] shadow_children [MAX_ENTRIES];
  int unsigned shadow_used;
  int unsigned shadow_capacity;

  node_result_t awaited_results[$];
  int error_count = 0;
  bit stall_free = 1'b0;
  bit hold_request = 1'b0;

  btree_index_node_engine_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_child        (in_child),
    .in_second_child (in_second_child),
    .in_root_count   (in_root_count),
    .in_split_pos    (in_split_pos),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_key         (out_key),
    .out_child       (out_child),
    .out_entry_total (out_entry_total),
    .out_last        (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Last entry from index 1 on whose key is not above the search key
  function automatic int unsigned lookup_position(input logic [63:0] key);
    int unsigned i;
    i = 1;
    while (i < shadow_used && i < MAX_ENTRIES && !(shadow_keys[i] > key)) i++;
    return i - 1;
  endfunction

  // Apply one request to the shadow node and list the results it causes
  function automatic void node_model_step(input node_req_t r, ref node_result_t res[$]);
    int unsigned pos, cap, old, i;
    node_result_t o;
    res.delete();
    o = '0;
    o.last = 1'b1;
    case (r.op)
      OP_INIT: begin
        shadow_keys[0] = '0;
        shadow_children[0] = r.child;
        shadow_keys[1] = r.key;
        shadow_children[1] = r.second_child;
        shadow_used = (r.root_count == 2'd0) ? 1 : (r.root_count == 2'd3) ? 2 : r.root_count;
        o.status = ST_OK;
        o.entry_total = 7'(shadow_used);
        res.push_back(o);
      end
      OP_LOOKUP: begin
        if (shadow_used == 0) begin
          o.status = ST_EMPTY;
        end else begin
          pos = lookup_position(r.key);
          o.status = ST_OK;
          o.entry_index = 6'(pos);
          o.key = shadow_keys[pos];
          o.child = shadow_children[pos];
        end
        o.entry_total = 7'(shadow_used);
        res.push_back(o);
      end
      OP_ADD: begin
        cap = shadow_capacity;
        if (cap < 1) cap = 1;
        if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
        if (shadow_used == 0) begin
          o.status = ST_EMPTY;
        end else if (shadow_used >= cap) begin
          o.status = ST_FULL;
        end else begin
          // Open a gap just after the lookup position
          pos = lookup_position(r.key) + 1;
          for (i = shadow_used; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_children[i] = shadow_children[i-1];
          end
          shadow_keys[pos] = r.key;
          shadow_children[pos] = r.child;
          shadow_used++;
          o.status = ST_OK;
          o.entry_index = 6'(pos);
          o.key = r.key;
          o.child = r.child;
        end
        o.entry_total = 7'(shadow_used);
        res.push_back(o);
      end
      OP_UPDATE: begin
        if (shadow_used == 0) begin
          o.status = ST_EMPTY;
        end else begin
          pos = lookup_position(r.key);
          if (shadow_keys[pos] == r.key) begin
            shadow_children[pos] = r.child;
            o.status = ST_OK;
          end else begin
            o.status = ST_NOT_FOUND;
          end
          o.entry_index = 6'(pos);
          o.key = shadow_keys[pos];
          o.child = shadow_children[pos];
        end
        o.entry_total = 7'(shadow_used);
        res.push_back(o);
      end
      OP_SPLIT: begin
        old = shadow_used;
        if (r.split_pos > old) begin
          o.status = ST_BAD_SPLIT;
          o.entry_total = 7'(old);
          res.push_back(o);
        end else begin
          shadow_used = r.split_pos;
          if (r.split_pos == old) begin
            o.status = ST_OK;
            o.entry_total = 7'(shadow_used);
            res.push_back(o);
          end else begin
            // Emit the tail of the node in order
            for (i = r.split_pos; i < old; i++) begin
              o.status = ST_OK;
              o.entry_index = 6'(i - r.split_pos);
              o.key = shadow_keys[i];
              o.child = shadow_children[i];
              o.entry_total = 7'(shadow_used);
              o.last = (i + 1 == old);
              res.push_back(o);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Partly keys near those held, so that updates hit and inserts land mid-table
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(9))
      0, 1, 2, 3: k = {$urandom, $urandom};
      4, 5, 6: k = 64'($urandom_range(1000));
      default: begin
        if (shadow_used == 0) begin
          k = 64'($urandom_range(1000));
        end else begin
          k = shadow_keys[$urandom_range(shadow_used - 1)];
          case ($urandom_range(2))
            1: k = k + 64'd1;
            2: k = k - 64'd1;
            default: ;
          endcase
        end
      end
    endcase
    return k;
  endfunction

  function automatic node_req_t make_random_request(input int add_pct);
    node_req_t r;
    int unsigned sel;
    r.key = pick_key();
    r.child = {$urandom, $urandom};
    r.second_child = {$urandom, $urandom};
    r.root_count = 2'($urandom_range(3));
    sel = $urandom_range(9);
    if (sel < 6) r.split_pos = 7'($urandom_range(shadow_used));
    else if (sel < 8) r.split_pos = 7'(shadow_used);
    else r.split_pos = 7'($urandom_range(127));
    sel = $urandom_range(99);
    if (sel < 3) begin
      case ($urandom_range(2))
        0: r.op = OP_UNUSED_5;
        1: r.op = OP_UNUSED_6;
        default: r.op = OP_UNUSED_7;
      endcase
    end else if (shadow_used == 0 ? sel < 60 : sel < 6) begin
      r.op = OP_INIT;
    end else if ($urandom_range(99) < add_pct) begin
      r.op = OP_ADD;
    end else begin
      case ($urandom_range(2))
        0: r.op = OP_LOOKUP;
        1: r.op = OP_UPDATE;
        default: r.op = OP_SPLIT;
      endcase
    end
    return r;
  endfunction

  // Offer one request; predict its results once it is taken
  task automatic drive_request(input node_req_t r, input logic typed, input node_result_t want);
    node_result_t produced[$];
    while (!stall_free && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= r.op;
    in_key <= r.key;
    in_child <= r.child;
    in_second_child <= r.second_child;
    in_root_count <= r.root_count;
    in_split_pos <= r.split_pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    node_model_step(r, produced);
    if (typed) awaited_results.push_back(want);
    else foreach (produced[i]) awaited_results.push_back(produced[i]);
    @(negedge clk);
  endtask

  // Drop valid, wait for every awaited result, then let the block go quiet
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (extra + 1) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    settle(SETTLE_CYCLES);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = value;
  endtask

  function automatic void compare_field(input string name, input logic [63:0] expected,
                                        input logic [63:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endfunction

  // Check each taken result against the oldest awaited one
  always @(posedge clk) begin
    node_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d, entry_index %0d", out_status, out_entry_index);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", 64'(want.status), 64'(out_status));
        compare_field("entry_index", 64'(want.entry_index), 64'(out_entry_index));
        compare_field("out_key", want.key, out_key);
        compare_field("out_child", want.child, out_child);
        compare_field("entry_total", 64'(want.entry_total), 64'(out_entry_total));
        compare_field("last", 64'(want.last), 64'(out_last));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    bit stall_now;
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        stall_now = 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        stall_now = 1'b1;
      end else begin
        stall_now = !stall_free && ($urandom_range(99) < 28);
      end
      out_stall <= stall_now;
    end
  end

  initial begin
    node_req_t r;
    logic [6:0] cap;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_INIT;
    in_key = '0;
    in_child = '0;
    in_second_child = '0;
    in_root_count = '0;
    in_split_pos = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
      shadow_children[i] = '0;
    end
    shadow_used = 0;
    shadow_capacity = 64;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) write_capacity(DIRECTED[i].cfg_value);
      else drive_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases, one capacity each
    for (int ph = 0; ph < PHASES; ph++) begin
      cap = (ph == 3) ? 7'($urandom_range(2, 40)) : PHASE_CAP[ph];
      write_capacity(cap);
      stall_free = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
        if (ph == 2 && n == 10) hold_request = 1'b1;
        if (ph == 3 && n == 20) settle(0);
        drive_request(make_random_request(PHASE_ADD_PCT[ph]), 1'b0, NO_RES);
      end
      // Empty the grown node in one long run
      if (ph == 0) begin
        r = make_random_request(0);
        r.op = OP_SPLIT;
        r.split_pos = '0;
        drive_request(r, 1'b0, NO_RES);
      end
    end
    stall_free = 1'b0;

    settle(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
